// File: hw/rtl/adrc_pkg.sv
// ----------------------------------------------------------------------------
// adrc_pkg
// Types, register indexes and constants shared by the compressor modules.
// ----------------------------------------------------------------------------
package adrc_pkg;

   localparam int Q16_BITS = 17;
   localparam logic [Q16_BITS-1:0] Q16_ONE = 17'h10000;
   localparam int COEF_BITS = 32;
   localparam int DIV_STEPS = 32;
   localparam int DIV_STEP_BITS = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KNEE_MODE = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_RATIO     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_LINEAR,
      OP_KNEE
   } op_type;

   typedef enum logic [1:0] {
      COEF_IDLE,
      COEF_LOAD,
      COEF_RUN
   } coef_state_type;

   typedef struct packed {
      logic                  soft_knee;
      logic [Q16_BITS-1:0]   threshold;
      logic [Q16_BITS-1:0]   ratio;
      logic [COEF_BITS-1:0]  coef;
      logic                  busy;
   } cfg_type;

   typedef struct packed {
      op_type op;
      logic   neg;
      logic   last;
   } ctl_type;

   function automatic logic [Q16_BITS-1:0] sat_q16(input logic [Q16_BITS-1:0] v);
      return (v > Q16_ONE) ? Q16_ONE : v;
   endfunction

endpackage

// File: hw/rtl/adrc_if.sv
// ----------------------------------------------------------------------------
// adrc_if
// Valid/ready channels for sample items into and out of the compressor.
// ----------------------------------------------------------------------------
interface adrc_req_if #(parameter int SAMPLE_BITS = 24) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          last_in;

   modport source (output valid, sample_in, last_in, input ready);
   modport sink (input valid, sample_in, last_in, output ready);
endinterface

interface adrc_rsp_if #(parameter int SAMPLE_BITS = 24) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          last_out;

   modport source (output valid, sample_out, last_out, input ready);
   modport sink (input valid, sample_out, last_out, output ready);
endinterface

// File: hw/rtl/adrc_coef.sv
// ----------------------------------------------------------------------------
// adrc_coef
// Configuration registers and the bit-serial divider for the soft knee slope.
// ----------------------------------------------------------------------------
module adrc_coef (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [adrc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adrc_pkg::Q16_BITS-1:0]       csr_wdata,
   output adrc_pkg::cfg_type                   cfg
);
   import adrc_pkg::*;

   logic                     knee_ff;
   logic [Q16_BITS-1:0]      thr_ff;
   logic [Q16_BITS-1:0]      ratio_ff;
   logic [COEF_BITS-1:0]     coef_ff, coef_in;
   coef_state_type           state_ff, state_in;
   logic [COEF_BITS-1:0]     num_ff, num_in;
   logic [COEF_BITS-1:0]     quo_ff, quo_in;
   logic [Q16_BITS-1:0]      den_ff, den_in;
   logic [Q16_BITS-1:0]      rem_ff, rem_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic                     cfg_write;

   assign cfg_write = csr_we && (csr_index inside {CSR_KNEE_MODE, CSR_THRESHOLD, CSR_RATIO});

   always_ff @(posedge clock) begin
      if (reset) begin
         knee_ff  <= 1'b0;
         thr_ff   <= '0;
         ratio_ff <= Q16_ONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KNEE_MODE: knee_ff <= csr_wdata[0];
            CSR_THRESHOLD: thr_ff <= sat_q16(csr_wdata);
            CSR_RATIO:     ratio_ff <= sat_q16(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= COEF_IDLE;
         coef_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         coef_ff  <= coef_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      logic [Q16_BITS:0]    rem_shift;
      logic [Q16_BITS:0]    rem_sub;
      logic [Q16_BITS-1:0]  rem_next;
      logic [COEF_BITS-1:0] quo_next;

      state_in = state_ff;
      coef_in  = coef_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;

      rem_shift = {rem_ff, num_ff[COEF_BITS-1]};
      rem_sub   = rem_shift - {1'b0, den_ff};
      if (rem_shift >= {1'b0, den_ff}) begin
         rem_next = rem_sub[Q16_BITS-1:0];
         quo_next = {quo_ff[COEF_BITS-2:0], 1'b1};
      end else begin
         rem_next = rem_shift[Q16_BITS-1:0];
         quo_next = {quo_ff[COEF_BITS-2:0], 1'b0};
      end

      case (state_ff)
         COEF_IDLE: ;
         COEF_LOAD: begin
            num_in  = {Q16_ONE - ratio_ff, 15'b0};
            den_in  = Q16_ONE - thr_ff;
            rem_in  = '0;
            quo_in  = '0;
            step_in = '0;
            if (thr_ff == Q16_ONE) begin
               coef_in  = '0;
               state_in = COEF_IDLE;
            end else begin
               state_in = COEF_RUN;
            end
         end
         COEF_RUN: begin
            num_in  = {num_ff[COEF_BITS-2:0], 1'b0};
            rem_in  = rem_next;
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_STEP_BITS'(DIV_STEPS - 1)) begin
               coef_in  = quo_next + COEF_BITS'(rem_next != '0);
               state_in = COEF_IDLE;
            end
         end
         default: state_in = COEF_IDLE;
      endcase

      if (cfg_write) begin
         state_in = COEF_LOAD;
      end
   end

   assign cfg.soft_knee = knee_ff;
   assign cfg.threshold = thr_ff;
   assign cfg.ratio     = ratio_ff;
   assign cfg.coef      = coef_ff;
   assign cfg.busy      = state_ff != COEF_IDLE;

   // With a unit ratio the numerator is zero, so a settled slope must be zero.
   a_unit_ratio_zero_coef: assert property (@(posedge clock) disable iff (reset)
      (state_ff == COEF_IDLE && ratio_ff == Q16_ONE) |-> coef_ff == '0)
      else $error("knee slope not zero at unit ratio");

   a_run_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == COEF_RUN |-> den_ff != '0)
      else $error("divider running with zero divisor");

endmodule

// File: hw/rtl/adrc_front.sv
// ----------------------------------------------------------------------------
// adrc_front
// Takes sample items, forms the magnitude and sorts each into a curve region.
// ----------------------------------------------------------------------------
module adrc_front #(
   parameter int SAMPLE_BITS = 24
) (
   adrc_req_if.sink                  req_ch,
   input  adrc_pkg::cfg_type         cfg,
   output logic                      q_valid,
   input  logic                      q_ready,
   output adrc_pkg::ctl_type         q_ctl,
   output logic [SAMPLE_BITS-1:0]    q_mag,
   output logic [SAMPLE_BITS-1:0]    q_base,
   output logic [SAMPLE_BITS-1:0]    q_diff
);
   import adrc_pkg::*;

   localparam int FRAC = SAMPLE_BITS - 2;
   localparam int UP   = (FRAC >= 16) ? FRAC - 16 : 0;
   localparam int DOWN = (FRAC < 16) ? 16 - FRAC : 0;
   localparam int WIDE = SAMPLE_BITS + Q16_BITS;

   logic [WIDE-1:0]        thr_wide;
   logic [SAMPLE_BITS-1:0] thr;
   logic [SAMPLE_BITS-1:0] one;
   logic                   neg;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] base;
   op_type                 op;

   assign thr_wide = (WIDE'(cfg.threshold) << UP) >> DOWN;
   assign thr      = thr_wide[SAMPLE_BITS-1:0];
   assign one      = SAMPLE_BITS'(1) << FRAC;
   assign neg      = req_ch.sample_in[SAMPLE_BITS-1];
   assign mag      = neg ? ({SAMPLE_BITS{1'b0}} - $unsigned(req_ch.sample_in))
                         : $unsigned(req_ch.sample_in);

   always_comb begin
      op   = OP_PASS;
      base = mag;
      if (cfg.ratio != Q16_ONE) begin
         if (!cfg.soft_knee) begin
            if (mag > thr) begin
               op   = OP_LINEAR;
               base = thr;
            end
         end else if (mag > one) begin
            op   = OP_LINEAR;
            base = one;
         end else if (mag > thr) begin
            op   = OP_KNEE;
            base = thr;
         end
      end
   end

   assign req_ch.ready = q_ready && !cfg.busy;
   assign q_valid      = req_ch.valid && !cfg.busy;
   assign q_ctl.op     = op;
   assign q_ctl.neg    = neg;
   assign q_ctl.last   = req_ch.last_in;
   assign q_mag        = mag;
   assign q_base       = base;
   assign q_diff       = mag - base;

endmodule

// File: hw/rtl/adrc_queue.sv
// ----------------------------------------------------------------------------
// adrc_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module adrc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count above depth");

endmodule

// File: hw/rtl/adrc_back.sv
// ----------------------------------------------------------------------------
// adrc_back
// Four-stage pipeline that evaluates the compression curve for each item.
// ----------------------------------------------------------------------------
module adrc_back #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  adrc_pkg::cfg_type      cfg,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  adrc_pkg::ctl_type      q_ctl,
   input  logic [SAMPLE_BITS-1:0] q_mag,
   input  logic [SAMPLE_BITS-1:0] q_base,
   input  logic [SAMPLE_BITS-1:0] q_diff,
   adrc_rsp_if.source             rsp_ch
);
   import adrc_pkg::*;

   localparam int FRAC = SAMPLE_BITS - 2;
   localparam int P1   = SAMPLE_BITS + COEF_BITS;
   localparam int RW   = P1 - 16;

   logic adv1, adv2, adv3, adv4;

   logic                   s1_v_ff;
   ctl_type                s1_ctl_ff;
   logic [SAMPLE_BITS-1:0] s1_mag_ff, s1_base_ff, s1_diff_ff;
   logic [P1-1:0]          s1_prod_ff, s1_prod_in;
   logic [COEF_BITS-1:0]   mul_a;

   logic                   s2_v_ff;
   ctl_type                s2_ctl_ff;
   logic [SAMPLE_BITS-1:0] s2_mag_ff, s2_diff_ff;
   logic [SAMPLE_BITS-1:0] s2_y_ff, s2_y_in;
   logic [COEF_BITS-1:0]   s2_p_ff, s2_p_in;
   logic [P1-1:0]          knee_sum;

   logic                   s3_v_ff;
   ctl_type                s3_ctl_ff;
   logic [SAMPLE_BITS-1:0] s3_mag_ff, s3_y_ff;
   logic [P1-1:0]          s3_prod_ff, s3_prod_in;

   logic                   s4_v_ff;
   ctl_type                s4_ctl_ff;
   logic [SAMPLE_BITS-1:0] s4_sample_ff, s4_sample_in;
   logic [P1-1:0]          red_sum;
   logic [RW-1:0]          red;
   logic [SAMPLE_BITS-1:0] y_knee, y_final;

   assign adv4    = !s4_v_ff || rsp_ch.ready;
   assign adv3    = !s3_v_ff || adv4;
   assign adv2    = !s2_v_ff || adv3;
   assign adv1    = !s1_v_ff || adv2;
   assign q_ready = adv1;

   assign mul_a      = (q_ctl.op == OP_KNEE) ? cfg.coef : COEF_BITS'(cfg.ratio);
   assign s1_prod_in = P1'(q_diff) * P1'(mul_a);

   assign knee_sum = s1_prod_ff + P1'((SAMPLE_BITS'(1) << FRAC) - 1'b1);
   assign s2_p_in  = knee_sum[FRAC +: COEF_BITS];
   always_comb begin
      s2_y_in = s1_mag_ff;
      if (s1_ctl_ff.op == OP_LINEAR) begin
         s2_y_in = s1_base_ff + s1_prod_ff[16 +: SAMPLE_BITS];
      end
   end

   assign s3_prod_in = P1'(s2_p_ff) * P1'(s2_diff_ff);

   assign red_sum = s3_prod_ff + P1'(16'hFFFF);
   assign red     = red_sum[P1-1:16];
   assign y_knee  = (red > RW'(s3_mag_ff)) ? '0 : s3_mag_ff - red[SAMPLE_BITS-1:0];
   assign y_final = (s3_ctl_ff.op == OP_KNEE) ? y_knee : s3_y_ff;
   assign s4_sample_in = s3_ctl_ff.neg ? ({SAMPLE_BITS{1'b0}} - y_final) : y_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_v_ff <= q_valid;
         end
         if (adv2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (adv3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (adv4) begin
            s4_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ctl_ff  <= q_ctl;
         s1_mag_ff  <= q_mag;
         s1_base_ff <= q_base;
         s1_diff_ff <= q_diff;
         s1_prod_ff <= s1_prod_in;
      end
      if (adv2) begin
         s2_ctl_ff  <= s1_ctl_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_diff_ff <= s1_diff_ff;
         s2_y_ff    <= s2_y_in;
         s2_p_ff    <= s2_p_in;
      end
      if (adv3) begin
         s3_ctl_ff  <= s2_ctl_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_y_ff    <= s2_y_ff;
         s3_prod_ff <= s3_prod_in;
      end
      if (adv4) begin
         s4_ctl_ff    <= s3_ctl_ff;
         s4_sample_ff <= s4_sample_in;
      end
   end

   assign rsp_ch.valid      = s4_v_ff;
   assign rsp_ch.sample_out = s4_sample_ff;
   assign rsp_ch.last_out   = s4_ctl_ff.last;

   a_linear_not_above_input: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_ctl_ff.op != OP_KNEE) |-> s2_y_ff <= s2_mag_ff)
      else $error("compressed magnitude above input magnitude");

   a_positive_keeps_sign: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && !s4_ctl_ff.neg) |-> !s4_sample_ff[SAMPLE_BITS-1])
      else $error("positive item produced a negative result");

endmodule

// File: hw/rtl/audio_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor
// Hard or soft knee compressor for signed Q2.(SAMPLE_BITS-2) audio samples.
// The block takes one sample item per clock and returns one compressed item
// per clock while the result side is not stalled and no slope is being
// computed. Each accepted item passes the input queue and four pipeline
// stages, set by the two multiplications of the soft knee curve. A write to
// any of the three configuration registers recomputes the soft knee slope in
// a one-bit-per-step divider, so no sample item is taken until the division
// ends, or until the load step ends when the threshold is 1.0.
// ----------------------------------------------------------------------------
module audio_dynamic_range_compressor #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   adrc_req_if.sink                            req_ch,
   adrc_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [adrc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adrc_pkg::Q16_BITS-1:0]       csr_wdata
);
   import adrc_pkg::*;

   localparam int CTL_BITS = $bits(ctl_type);
   localparam int Q_WIDTH  = CTL_BITS + 3 * SAMPLE_BITS;

   cfg_type                cfg;
   logic                   f_valid, f_ready;
   ctl_type                f_ctl, b_ctl;
   logic [SAMPLE_BITS-1:0] f_mag, f_base, f_diff;
   logic [SAMPLE_BITS-1:0] b_mag, b_base, b_diff;
   logic                   b_valid, b_ready;
   logic [Q_WIDTH-1:0]     push_data, pop_data;

   adrc_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   adrc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .req_ch  (req_ch),
      .cfg     (cfg),
      .q_valid (f_valid),
      .q_ready (f_ready),
      .q_ctl   (f_ctl),
      .q_mag   (f_mag),
      .q_base  (f_base),
      .q_diff  (f_diff)
   );

   assign push_data = {f_ctl, f_mag, f_base, f_diff};

   adrc_queue #(.WIDTH(Q_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (push_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (pop_data)
   );

   assign {b_ctl, b_mag, b_base, b_diff} = pop_data;

   adrc_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (b_valid),
      .q_ready (b_ready),
      .q_ctl   (b_ctl),
      .q_mag   (b_mag),
      .q_base  (b_base),
      .q_diff  (b_diff),
      .rsp_ch  (rsp_ch)
   );

endmodule

// File: bench/audio_dynamic_range_compressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor_tb
// Self-checking bench for the compressor. Every accepted sample item is run
// through an independent model of the hard and soft knee curves, and each
// returned item is compared in order against that prediction. The run steps
// through many register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module audio_dynamic_range_compressor_tb;
   import adrc_pkg::*;

   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS = SAMPLE_BITS - 2;
   localparam int HALF_PERIOD = 6;
   localparam int IDLE_PERCENT = 13;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RESET_ITEMS = 60;
   localparam int FIXED_ITEMS = 70;
   localparam int RANDOM_ITEMS = 45;
   localparam int RANDOM_SETTINGS = 6;
   localparam int STEADY_SETTING = 3;
   localparam int DRAIN_SETTING = 6;
   localparam longint unsigned UNIT_Q16 = 65536;
   localparam longint unsigned UNIT_SAMPLE = 64'd1 << FRAC_BITS;
   localparam longint unsigned SAMPLE_SPAN = 64'd1 << SAMPLE_BITS;
   localparam int SAMPLE_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam int SAMPLE_MIN = -(2 ** (SAMPLE_BITS - 1));
   localparam int UNIT_INT = 2 ** FRAC_BITS;
   localparam int HALF_INT = 2 ** (FRAC_BITS - 1);
   localparam logic [Q16_BITS-1:0] HALF_Q16 = 17'd32768;
   localparam logic [Q16_BITS-1:0] QUARTER_Q16 = 17'd16384;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } compressed_item_type;

   typedef struct packed {
      logic                soft_mode;
      logic [Q16_BITS-1:0] threshold;
      logic [Q16_BITS-1:0] ratio;
   } curve_setting_type;

   class compressed_sample_tracker;
      bit                  soft_knee;
      bit [Q16_BITS-1:0]   threshold;
      bit [Q16_BITS-1:0]   ratio;
      bit [COEF_BITS-1:0]  knee_slope;
      compressed_item_type expected_samples[$];
      int unsigned         failures;
      int unsigned         matched;

      function new();
         soft_knee = 1'b0;
         threshold = '0;
         ratio = Q16_ONE;
         knee_slope = '0;
         failures = 0;
         matched = 0;
      endfunction

      function longint unsigned clamp_unit(bit [Q16_BITS-1:0] v);
         return (v > UNIT_Q16) ? UNIT_Q16 : longint'(v);
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [Q16_BITS-1:0] value);
         longint unsigned span;
         case (index)
            CSR_KNEE_MODE: soft_knee = value[0];
            CSR_THRESHOLD: threshold = value;
            CSR_RATIO: ratio = value;
            default: return;
         endcase
         span = UNIT_Q16 - clamp_unit(threshold);
         if (span == 0) begin
            knee_slope = '0;
         end else begin
            knee_slope = COEF_BITS'(((UNIT_Q16 - clamp_unit(ratio)) * 32768 + span - 1)
                                    / span);
         end
      endfunction

      function longint unsigned compress_magnitude(longint unsigned mag);
         longint unsigned r, knee_point, d, p, cut;
         r = clamp_unit(ratio);
         knee_point = clamp_unit(threshold) << (FRAC_BITS - 16);
         if (r == UNIT_Q16) return mag;
         if (!soft_knee) begin
            return (mag > knee_point) ? knee_point + (((mag - knee_point) * r) >> 16) : mag;
         end
         if (mag > UNIT_SAMPLE) return UNIT_SAMPLE + (((mag - UNIT_SAMPLE) * r) >> 16);
         if (mag > knee_point) begin
            d = mag - knee_point;
            p = (longint'(knee_slope) * d + UNIT_SAMPLE - 1) >> FRAC_BITS;
            cut = (p * d + UNIT_Q16 - 1) >> 16;
            return (cut > mag) ? 0 : mag - cut;
         end
         return mag;
      endfunction

      function void take_sample(logic signed [SAMPLE_BITS-1:0] value_in, logic last_in);
         bit [SAMPLE_BITS-1:0] raw;
         longint unsigned mag, shaped;
         compressed_item_type item;
         raw = value_in;
         mag = raw[SAMPLE_BITS-1] ? SAMPLE_SPAN - raw : raw;
         shaped = compress_magnitude(mag);
         item.sample = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(SAMPLE_SPAN - shaped)
                                          : SAMPLE_BITS'(shaped);
         item.last = last_in;
         expected_samples.push_back(item);
      endfunction

      function void match_sample(logic signed [SAMPLE_BITS-1:0] got_sample, logic got_last);
         compressed_item_type want;
         if (expected_samples.size() == 0) begin
            $display("%0t: result item with nothing expected, sample_out %0d last_out %0b",
                     $time, got_sample, got_last);
            failures++;
            return;
         end
         want = expected_samples.pop_front();
         if (got_sample !== want.sample) begin
            $display("%0t: sample_out expected %0d, actual %0d", $time, want.sample, got_sample);
            failures++;
         end
         if (got_last !== want.last) begin
            $display("%0t: last_out expected %0b, actual %0b", $time, want.last, got_last);
            failures++;
         end
         matched++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [Q16_BITS-1:0] csr_wdata;
   bit steady;
   bit spare_written;
   int unsigned stall_cycles;
   int unsigned settings_used;
   compressed_sample_tracker tracker;

   adrc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   adrc_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_ch ();

   audio_dynamic_range_compressor #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   logic signed [SAMPLE_BITS-1:0] corner_samples[12] = '{
      0, 1, -1, SAMPLE_MAX, SAMPLE_MIN, UNIT_INT, -UNIT_INT, UNIT_INT + 1,
      -(UNIT_INT + 1), HALF_INT, HALF_INT + 1, -(HALF_INT + 1)
   };

   curve_setting_type fixed_settings[10] = '{
      '{1'b0, 17'd0, 17'd0},
      '{1'b1, 17'd0, 17'd0},
      '{1'b0, 17'd65536, 17'd0},
      '{1'b1, 17'd65536, 17'd0},
      '{1'b1, 17'd131071, 17'd131071},
      '{1'b0, 17'd70000, 17'd30000},
      '{1'b1, 17'd65535, 17'd65535},
      '{1'b0, 17'd1, 17'd65535},
      '{1'b1, 17'd16384, 17'd49152},
      '{1'b0, 17'd49152, 17'd65536}
   };

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         tracker.match_sample(rsp_ch.sample_out, rsp_ch.last_out);
      end
      rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      longint unsigned knee_point, mag;
      knee_point = tracker.clamp_unit(tracker.threshold) << (FRAC_BITS - 16);
      case ($urandom_range(9))
         0, 1, 2, 3: return SAMPLE_BITS'($urandom());
         4, 5, 6: mag = $urandom_range(UNIT_INT + UNIT_INT / 4);
         7: mag = UNIT_SAMPLE - 64 + $urandom_range(128);
         8: begin
            mag = knee_point + $urandom_range(128);
            mag = (mag > 64) ? mag - 64 : mag;
         end
         default: mag = $urandom_range(255);
      endcase
      return $urandom_range(1) ? SAMPLE_BITS'(SAMPLE_SPAN - mag) : SAMPLE_BITS'(mag);
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value_in,
                              input logic last_in);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sample_in <= value_in;
      req_ch.last_in <= last_in;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.take_sample(value_in, last_in);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_sample(pick_sample(), $urandom_range(7) == 0);
   endtask

   task automatic wait_drained();
      while (tracker.expected_samples.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [Q16_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(index, value);
   endtask

   task automatic program_setting(input curve_setting_type setting);
      logic [Q16_BITS-1:0] mode_word;
      req_ch.valid <= 1'b0;
      wait_drained();
      mode_word = Q16_BITS'($urandom());
      mode_word[0] = setting.soft_mode;
      write_csr(CSR_KNEE_MODE, mode_word);
      write_csr(CSR_THRESHOLD, setting.threshold);
      write_csr(CSR_RATIO, setting.ratio);
      if (!spare_written || $urandom_range(3) == 0) begin
         write_csr(CSR_SPARE, Q16_BITS'($urandom()));
         spare_written = 1'b1;
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      curve_setting_type setting;
      tracker = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.sample_in = '0;
      req_ch.last_in = 1'b0;
      rsp_ch.ready = 1'b0;
      steady = 1'b0;
      spare_written = 1'b0;
      stall_cycles = 0;
      settings_used = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_random(RESET_ITEMS);

      for (int mode = 0; mode < 2; mode++) begin
         program_setting('{mode[0], HALF_Q16, QUARTER_Q16});
         foreach (corner_samples[i]) send_sample(corner_samples[i], i[0]);
      end

      foreach (fixed_settings[i]) begin
         program_setting(fixed_settings[i]);
         steady = (i == STEADY_SETTING);
         if (i == DRAIN_SETTING) begin
            send_random(FIXED_ITEMS / 2);
            req_ch.valid <= 1'b0;
            wait_drained();
            send_random(FIXED_ITEMS - FIXED_ITEMS / 2);
         end else begin
            send_random(FIXED_ITEMS);
         end
      end
      steady = 1'b0;

      repeat (RANDOM_SETTINGS) begin
         setting.soft_mode = 1'($urandom_range(1));
         setting.threshold = ($urandom_range(4) == 0) ? Q16_BITS'($urandom())
                                                      : Q16_BITS'($urandom_range(65536));
         setting.ratio = ($urandom_range(4) == 0) ? Q16_BITS'($urandom())
                                                  : Q16_BITS'($urandom_range(65536));
         program_setting(setting);
         send_random(RANDOM_ITEMS);
      end

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.expected_samples.size() != 0) begin
         $display("%0t: %0d expected samples never returned", $time,
                  tracker.expected_samples.size());
         tracker.failures++;
      end
      $display("Compared %0d compressed samples across %0d register settings,",
               tracker.matched, settings_used);
      $display("covering both knee modes, saturated registers and full-scale inputs.");
      if (tracker.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
